/* src/qasr_pkg.sv */
// Shared constants, types and configuration layout for the quote-aware replacer.
package qasr_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned MaxReplaceDef = 16;

  // Configuration register file
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgLenW  = 5;
  localparam int unsigned CfgBytes = 16;

  localparam logic [CfgIdxW-1:0] REG_SEARCH_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SEARCH_HIGH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SEARCH_LEN   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPLACE_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REPLACE_HIGH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REPLACE_LEN  = 3'd5;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // Token queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    TOK_BYTE,
    TOK_REPL,
    TOK_MARK
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e                 kind;
    logic [7:0]                data;
    logic                      run_last;
    logic                      stream_end;
    logic [CfgLenW-1:0]        rlen;
    logic [CfgBytes*8-1:0]     rep;
  } tok_t;

  typedef struct packed {
    logic [CfgBytes*8-1:0] search;
    logic [CfgLenW-1:0]    search_len;
    logic [CfgBytes*8-1:0] replace;
    logic [CfgLenW-1:0]    replace_len;
  } cfg_t;

endpackage

/* src/qasr_front.sv */
// Front end: lookahead, quote tracking, matching; one action per cycle unless stalled.
module qasr_front import qasr_pkg::*; #(
  parameter int unsigned MAX_PATTERN     = MaxPatternDef,
  parameter int unsigned MAX_REPLACEMENT = MaxReplaceDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       in_stall_o,
  input  cfg_t       cfg_i,
  input  logic       q_full_i,
  output logic       push_o,
  output tok_t       tok_o
);

  localparam int unsigned CntW = $clog2(MAX_PATTERN + 1);

  logic [7:0]         win_q [MAX_PATTERN];
  logic [7:0]         win_d [MAX_PATTERN];
  logic [7:0]         pat_q [MAX_PATTERN];
  logic [7:0]         pat_d [MAX_PATTERN];
  logic [CntW-1:0]    cnt_q, cnt_d, cnt_b, cnt_n;
  logic [CntW-1:0]    plen_q, plen_d;
  logic [CfgLenW-1:0] rlen_q, rlen_d;
  logic [CfgBytes*8-1:0] rep_q, rep_d;
  logic               inq_q, inq_d, inq_n;
  logic               bso_q, bso_d, bso_n;
  logic               last_q, last_d;

  logic [7:0] head, head_nxt;
  logic       pat_ok, stuck, stuck_n, is_match, final_act, push_need, do_act;
  logic       accept, latch;

  always_comb begin
    head     = win_q[0];
    head_nxt = '0;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      if (i == 1) head_nxt = win_q[i];
    end
    pat_ok = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (CntW'(k) < plen_q && win_q[k] != pat_q[k]) pat_ok = 1'b0;
    end
  end

  // window is stuck when empty or waiting for more lookahead
  assign stuck = (cnt_q == '0) ||
                 (!inq_q && head != ChQuote && plen_q != '0 && cnt_q < plen_q && !last_q);
  assign is_match = !inq_q && head != ChQuote && plen_q != '0 && cnt_q >= plen_q && pat_ok;

  always_comb begin
    inq_n = inq_q;
    bso_n = bso_q;
    if (inq_q) begin
      if (head == ChBackslash) begin
        bso_n = !bso_q;
      end else begin
        if (head == ChQuote && !bso_q) inq_n = 1'b0;
        bso_n = 1'b0;
      end
    end else if (head == ChQuote) begin
      inq_n = 1'b1;
      bso_n = 1'b0;
    end
  end

  assign cnt_n   = is_match ? '0 : cnt_q - CntW'(1);
  assign stuck_n = (cnt_n == '0) ||
                   (!inq_n && head_nxt != ChQuote && plen_q != '0 && cnt_n < plen_q && !last_q);
  // a match always empties the window, so it ends its step
  assign final_act = is_match || stuck_n;
  assign push_need = !is_match || rlen_q != '0 || last_q;
  assign do_act    = !stuck && (!push_need || !q_full_i);
  assign in_stall_o = !(stuck || (do_act && final_act));
  assign accept    = in_valid_i && !in_stall_o;
  assign push_o    = do_act && push_need;

  always_comb begin
    tok_o.kind       = TOK_BYTE;
    tok_o.data       = head;
    tok_o.run_last   = final_act;
    tok_o.stream_end = final_act && last_q;
    tok_o.rlen       = rlen_q;
    tok_o.rep        = rep_q;
    if (is_match) begin
      if (rlen_q == '0) begin
        tok_o.kind = TOK_MARK;
        tok_o.data = '0;
      end else begin
        tok_o.kind = TOK_REPL;
      end
    end
  end

  always_comb begin
    win_d  = win_q;
    cnt_b  = cnt_q;
    inq_d  = inq_q;
    bso_d  = bso_q;
    last_d = last_q;
    if (do_act) begin
      for (int i = 0; i + 1 < MAX_PATTERN; i++) win_d[i] = win_q[i+1];
      cnt_b = cnt_n;
      inq_d = inq_n;
      bso_d = bso_n;
      if (final_act && last_q) begin
        inq_d = 1'b0;
        bso_d = 1'b0;
      end
    end
    cnt_d = cnt_b;
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (cnt_b == CntW'(i)) win_d[i] = in_byte_i;
      end
      cnt_d  = cnt_b + CntW'(1);
      last_d = is_last_i;
    end
  end

  // settings are taken only when a step starts on an empty window
  assign latch = accept && cnt_b == '0;

  always_comb begin
    pat_d  = pat_q;
    rep_d  = rep_q;
    plen_d = plen_q;
    rlen_d = rlen_q;
    if (latch) begin
      for (int i = 0; i < MAX_PATTERN; i++) pat_d[i] = cfg_i.search[8*i +: 8];
      rep_d  = cfg_i.replace;
      plen_d = (cfg_i.search_len > CfgLenW'(MAX_PATTERN)) ? CntW'(MAX_PATTERN)
                                                           : cfg_i.search_len[CntW-1:0];
      rlen_d = (cfg_i.replace_len > CfgLenW'(MAX_REPLACEMENT)) ? CfgLenW'(MAX_REPLACEMENT)
                                                                : cfg_i.replace_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      inq_q  <= 1'b0;
      bso_q  <= 1'b0;
      last_q <= 1'b0;
      plen_q <= '0;
      rlen_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      inq_q  <= inq_d;
      bso_q  <= bso_d;
      last_q <= last_d;
      plen_q <= plen_d;
      rlen_q <= rlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    pat_q <= pat_d;
    rep_q <= rep_d;
  end

endmodule

/* src/qasr_queue.sv */
// Small token queue that decouples the front end from the back end.
module qasr_queue import qasr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t tok_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output tok_t tok_o
);

  tok_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign tok_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= tok_i;
  end

endmodule

/* src/qasr_back.sv */
// Back end: expands tokens into output beats and holds the output register.
module qasr_back import qasr_pkg::*; #(
  parameter int unsigned MAX_REPLACEMENT = MaxReplaceDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  tok_t       tok_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       stream_end_o
);

  localparam int unsigned IdxW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            byte_valid_q, byte_valid_d;
  logic            run_last_q, run_last_d;
  logic            stream_end_q, stream_end_d;

  logic       load, gen, tok_done;
  logic [7:0] rep_byte, data;
  logic       bvalid;

  assign load = !out_valid_q || !out_stall_i;
  assign gen  = load && q_valid_i;

  always_comb begin
    rep_byte = '0;
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      if (idx_q == IdxW'(i)) rep_byte = tok_i.rep[8*i +: 8];
    end
  end

  always_comb begin
    data     = tok_i.data;
    bvalid   = 1'b1;
    tok_done = 1'b1;
    case (tok_i.kind)
      TOK_BYTE: begin
        data = tok_i.data;
      end
      TOK_REPL: begin
        data     = rep_byte;
        tok_done = CfgLenW'(idx_q) + CfgLenW'(1) == tok_i.rlen;
      end
      TOK_MARK: begin
        data   = '0;
        bvalid = 1'b0;
      end
      default: begin
        data   = '0;
        bvalid = 1'b0;
      end
    endcase
  end

  assign pop_o = gen && tok_done;

  always_comb begin
    idx_d        = idx_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    run_last_d   = run_last_q;
    stream_end_d = stream_end_q;
    if (gen) idx_d = tok_done ? '0 : idx_q + IdxW'(1);
    if (load) begin
      out_valid_d  = gen;
      out_byte_d   = data;
      byte_valid_d = bvalid;
      run_last_d   = tok_i.run_last && tok_done;
      stream_end_d = tok_i.stream_end && tok_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    run_last_q   <= run_last_d;
    stream_end_q <= stream_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign run_last_o   = run_last_q;
  assign stream_end_o = stream_end_q;

endmodule

/* src/quote_aware_substring_replace.sv */
// Top level: configuration registers, front end, token queue and back end.
//
// Byte stream in, byte stream out. Outside double quotes each leftmost match of
// the search pattern is replaced by the replacement string; quoted text passes.
// Input beat: in_byte_i plus is_last_i, taken when in_valid_i is high and
// in_stall_o low. Output beat: out_byte_o, byte_valid_o, run_last_o and
// stream_end_o, taken when out_valid_o is high and out_stall_i low. run_last_o
// marks the last beat caused by one input byte; stream_end_o marks the end of
// the text, and a beat with byte_valid_o low is an empty end marker.
// A byte that completes its lookahead passes through the token queue and then
// the output register. Throughput: one input byte per cycle while bytes pass
// through and nothing stalls; a replacement of N bytes gives N output beats, and
// the input stalls once the two-entry token queue fills. The front end handles
// one window action per cycle; the output register sets the output rate.
// Settings are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle (the
// user's duty, not enforced) and apply once the lookahead window is empty. Reset
// clears the window, quote state and all settings at once; no clearing pass. A
// stall at the output holds the beat and backs up via the queue to in_stall_o.
module quote_aware_substring_replace import qasr_pkg::*; #(
  parameter int unsigned MAX_PATTERN     = MaxPatternDef,
  parameter int unsigned MAX_REPLACEMENT = MaxReplaceDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  input  logic                is_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                run_last_o,
  output logic                stream_end_o
);

  cfg_t cfg_q, cfg_d;
  logic q_push, q_full, q_pop, q_valid;
  tok_t q_wtok, q_rtok;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEARCH_LOW:   cfg_d.search[CfgDataW-1:0]             = cfg_data_i;
        REG_SEARCH_HIGH:  cfg_d.search[2*CfgDataW-1:CfgDataW]    = cfg_data_i;
        REG_SEARCH_LEN:   cfg_d.search_len                       = cfg_data_i[CfgLenW-1:0];
        REG_REPLACE_LOW:  cfg_d.replace[CfgDataW-1:0]            = cfg_data_i;
        REG_REPLACE_HIGH: cfg_d.replace[2*CfgDataW-1:CfgDataW]   = cfg_data_i;
        REG_REPLACE_LEN:  cfg_d.replace_len                      = cfg_data_i[CfgLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  qasr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .tok_o      (q_wtok)
  );

  qasr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .tok_i   (q_wtok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .tok_o   (q_rtok)
  );

  qasr_back #(
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .tok_i        (q_rtok),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

  // queue must never be written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("token queue overflow");

  // an empty marker only closes the text
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> stream_end_o && run_last_o && out_byte_o == 8'h00)
    else $error("empty marker outside end of text");

  // end of text closes the run of its input byte
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> run_last_o)
    else $error("stream end without run end");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("token queue underflow");

endmodule

/* tb/tb_quote_aware_substring_replace.sv */
// Self-checking testbench for the quote-aware substring replacer.
`timescale 1ns / 100ps

module tb_quote_aware_substring_replace;
  import qasr_pkg::*;

  localparam int unsigned MaxResults    = 31;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 43;
  localparam int unsigned MaxPrinted    = 30;
  localparam logic [7:0]  ChA           = 8'h61;
  localparam logic [7:0]  ChB           = 8'h62;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       stream_end;
  } beat_t;

  typedef struct packed {
    logic  used;
    beat_t beat;
  } pin_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_TEXT
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          b;
    logic                last;
    pin_t                pin;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          in_byte_i   = '0;
  logic                is_last_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                byte_valid_o;
  logic                run_last_o;
  logic                stream_end_o;

  quote_aware_substring_replace u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // predictor state: register shadows, latched setup, window, quote tracking
  logic [127:0]       sh_search      = '0;
  logic [127:0]       sh_replace     = '0;
  logic [CfgLenW-1:0] sh_search_len  = '0;
  logic [CfgLenW-1:0] sh_replace_len = '0;
  logic [127:0]       act_pat        = '0;
  logic [127:0]       act_rep        = '0;
  int unsigned        act_plen       = 0;
  int unsigned        act_rlen       = 0;
  logic [7:0]         win_q[$];
  logic               in_quote       = 1'b0;
  logic               bs_odd         = 1'b0;

  beat_t       step_beats_q[$];
  beat_t       text_out_q[$];
  pin_t        pinned_q[$];
  stim_row_t   dir_tbl[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned beats_in      = 0;
  int unsigned beats_out     = 0;
  int unsigned texts_done    = 0;
  int unsigned setups        = 0;

  // stimulus-side view of the current pattern
  logic [127:0] gen_pat  = '0;
  int unsigned  gen_plen = 0;

  function automatic void emit_beat(input logic [7:0] b, input logic valid);
    beat_t r;
    r = {b, valid, 1'b0, 1'b0};
    if (step_beats_q.size() < MaxResults) step_beats_q = {step_beats_q, r};
  endfunction

  // one input byte through the replacer; results land in step_beats_q
  function automatic void predict_step(input logic [7:0] b, input logic last);
    logic [7:0]  c;
    logic        hit;
    beat_t       r;
    int unsigned k;
    step_beats_q.delete();
    if (win_q.size() == 0) begin
      act_pat  = sh_search;
      act_rep  = sh_replace;
      act_plen = (sh_search_len > MaxPatternDef) ? MaxPatternDef : sh_search_len;
      act_rlen = (sh_replace_len > MaxReplaceDef) ? MaxReplaceDef : sh_replace_len;
    end
    if (win_q.size() < MaxPatternDef) win_q = {win_q, b};
    while (win_q.size() > 0) begin
      c = win_q[0];
      if (in_quote) begin
        emit_beat(c, 1'b1);
        if (c == ChBackslash) begin
          bs_odd = !bs_odd;
        end else begin
          if (c == ChQuote && !bs_odd) in_quote = 1'b0;
          bs_odd = 1'b0;
        end
        void'(win_q.pop_front());
      end else if (c == ChQuote) begin
        emit_beat(c, 1'b1);
        in_quote = 1'b1;
        bs_odd   = 1'b0;
        void'(win_q.pop_front());
      end else if (act_plen == 0) begin
        emit_beat(c, 1'b1);
        void'(win_q.pop_front());
      end else if (win_q.size() < act_plen) begin
        if (!last) break;
        emit_beat(c, 1'b1);
        void'(win_q.pop_front());
      end else begin
        hit = 1'b1;
        for (k = 0; k < act_plen; k++) begin
          if (win_q[k] != act_pat[8*k +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (k = 0; k < act_rlen; k++) emit_beat(act_rep[8*k +: 8], 1'b1);
          repeat (act_plen) void'(win_q.pop_front());
        end else begin
          emit_beat(c, 1'b1);
          void'(win_q.pop_front());
        end
      end
    end
    if (last) begin
      in_quote = 1'b0;
      bs_odd   = 1'b0;
      if (step_beats_q.size() == 0) emit_beat(8'h00, 1'b0);
      r = step_beats_q.pop_back();
      r.stream_end = 1'b1;
      step_beats_q = {step_beats_q, r};
    end
    if (step_beats_q.size() > 0) begin
      r = step_beats_q.pop_back();
      r.run_last = 1'b1;
      step_beats_q = {step_beats_q, r};
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < MaxPrinted)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // edge monitor: register shadows, prediction on input beats, checks on output beats
  always @(posedge clk_i) begin : monitor
    beat_t got;
    beat_t want;
    pin_t  pin;
    logic  busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        busy = 1'b1;
        case (cfg_idx_i)
          REG_SEARCH_LOW:   sh_search[63:0]    = cfg_data_i;
          REG_SEARCH_HIGH:  sh_search[127:64]  = cfg_data_i;
          REG_SEARCH_LEN:   sh_search_len      = cfg_data_i[CfgLenW-1:0];
          REG_REPLACE_LOW:  sh_replace[63:0]   = cfg_data_i;
          REG_REPLACE_HIGH: sh_replace[127:64] = cfg_data_i;
          REG_REPLACE_LEN:  sh_replace_len     = cfg_data_i[CfgLenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        busy = 1'b1;
        beats_in++;
        if (is_last_i) texts_done++;
        predict_step(in_byte_i, is_last_i);
        pin = '0;
        if (pinned_q.size() > 0) pin = pinned_q.pop_front();
        if (pin.used) text_out_q = {text_out_q, pin.beat};
        else foreach (step_beats_q[i]) text_out_q = {text_out_q, step_beats_q[i]};
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        beats_out++;
        got = {out_byte_o, byte_valid_o, run_last_o, stream_end_o};
        if (text_out_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 32'(got), 0);
        end else begin
          want = text_out_q.pop_front();
          if (got.data !== want.data)
            report_mismatch("out_byte", 32'(got.data), 32'(want.data));
          if (got.valid !== want.valid)
            report_mismatch("byte_valid", 32'(got.valid), 32'(want.valid));
          if (got.run_last !== want.run_last)
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
          if (got.stream_end !== want.stream_end)
            report_mismatch("stream_end", 32'(got.stream_end), 32'(want.stream_end));
        end
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WatchdogLimit);
    $display("%0t no handshake for %0d cycles", $realtime, WatchdogLimit);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // wait for every pending beat, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (text_out_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(9))
      0:       return ChQuote;
      1:       return ChBackslash;
      2, 3:    return ChA;
      4:       return ChB;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic load_random_setup();
    logic [127:0]       pat;
    logic [127:0]       rep;
    logic [CfgLenW-1:0] slen;
    logic [CfgLenW-1:0] rlen;
    int unsigned        k;
    for (k = 0; k < CfgBytes; k++) begin
      pat[8*k +: 8] = pick_text_byte();
      rep[8*k +: 8] = 8'($urandom_range(255));
    end
    case ($urandom_range(9))
      0:       slen = 5'd0;
      1:       slen = 5'd16;
      2:       slen = 5'($urandom_range(31, 17));
      default: slen = 5'($urandom_range(4, 1));
    endcase
    case ($urandom_range(9))
      0:       rlen = 5'd0;
      1:       rlen = 5'd16;
      2:       rlen = 5'($urandom_range(31, 17));
      default: rlen = 5'($urandom_range(5, 1));
    endcase
    write_reg(REG_SEARCH_LOW, pat[63:0]);
    write_reg(REG_SEARCH_HIGH, pat[127:64]);
    write_reg(REG_SEARCH_LEN, CfgDataW'(slen));
    write_reg(REG_REPLACE_LOW, rep[63:0]);
    write_reg(REG_REPLACE_HIGH, rep[127:64]);
    write_reg(REG_REPLACE_LEN, CfgDataW'(rlen));
    gen_pat  = pat;
    gen_plen = (slen > MaxPatternDef) ? MaxPatternDef : slen;
    setups++;
  endtask

  // pattern copies amid quotes, escapes and random bytes, plus some broken copies
  task automatic send_random_text();
    logic [7:0]  txt[$];
    int unsigned k;
    int unsigned cut;
    repeat ($urandom_range(5, 1)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          if (gen_plen == 0) txt = {txt, pick_text_byte()};
          for (k = 0; k < gen_plen; k++) txt = {txt, gen_pat[8*k +: 8]};
        end
        4: begin
          cut = (gen_plen > 0) ? $urandom_range(gen_plen - 1) : 0;
          for (k = 0; k < gen_plen; k++)
            txt = {txt, (k == cut) ? 8'($urandom_range(255)) : gen_pat[8*k +: 8]};
        end
        5: begin
          cut = (gen_plen > 0) ? $urandom_range(gen_plen - 1) : 0;
          for (k = 0; k < cut; k++) txt = {txt, gen_pat[8*k +: 8]};
        end
        6: txt = {txt, ChQuote};
        7: repeat ($urandom_range(3, 1)) txt = {txt, ChBackslash};
        default: txt = {txt, pick_text_byte()};
      endcase
    end
    if (txt.size() == 0) txt = {txt, 8'($urandom_range(255))};
    foreach (txt[i]) begin
      // now and then swap the setup while bytes sit in the window
      if (i + 1 < txt.size() && $urandom_range(29) == 0) begin
        settle();
        load_random_setup();
      end
      send_beat(txt[i], i + 1 == txt.size());
    end
  endtask

  function automatic stim_row_t row_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t row_text(input logic [7:0] b, input logic last);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_TEXT;
    row.b    = b;
    row.last = last;
    return row;
  endfunction

  function automatic stim_row_t row_pinned(input logic [7:0] b, input logic last,
                                           input beat_t beat);
    stim_row_t row;
    row          = row_text(b, last);
    row.pin.used = 1'b1;
    row.pin.beat = beat;
    return row;
  endfunction

  function automatic void add_row(input stim_row_t row);
    dir_tbl = {dir_tbl, row};
  endfunction

  initial begin : stimulus
    int unsigned goal;
    // empty pattern after reset: straight copy
    add_row(row_pinned(8'h00, 1'b0, {8'h00, 1'b1, 1'b1, 1'b0}));
    add_row(row_pinned(8'hFF, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b1}));
    // "ab" -> "XYZ"
    add_row(row_write(REG_SEARCH_LOW, 64'h6261));
    add_row(row_write(REG_SEARCH_HIGH, '1));
    add_row(row_write(REG_SEARCH_LEN, 64'd2));
    add_row(row_write(REG_REPLACE_LOW, 64'h5A5958));
    add_row(row_write(REG_REPLACE_HIGH, '0));
    add_row(row_write(REG_REPLACE_LEN, 64'd3));
    add_row(row_text(ChA, 1'b0));
    add_row(row_text(ChB, 1'b0));
    add_row(row_text(ChQuote, 1'b0));
    add_row(row_text(ChA, 1'b0));
    add_row(row_text(ChB, 1'b0));
    add_row(row_text(ChBackslash, 1'b0));
    add_row(row_text(ChQuote, 1'b0));        // escaped, string stays open
    add_row(row_text(ChBackslash, 1'b0));
    add_row(row_text(ChBackslash, 1'b0));
    add_row(row_text(ChQuote, 1'b0));        // even run, string closes
    add_row(row_text(ChA, 1'b0));
    add_row(row_text(ChQuote, 1'b0));
    add_row(row_text(8'h78, 1'b1));          // text ends inside quotes
    add_row(row_pinned(ChA, 1'b1, {ChA, 1'b1, 1'b1, 1'b1}));  // short tail
    // empty replacement consuming the last byte gives the end marker
    add_row(row_write(REG_REPLACE_LEN, '0));
    add_row(row_text(ChA, 1'b0));
    add_row(row_pinned(ChB, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}));
    // pattern a" with the quote eaten by the match; replacement length saturates
    add_row(row_write(REG_SEARCH_LOW, 64'hFFFF_FFFF_FFFF_2261));
    add_row(row_write(REG_REPLACE_LOW, '1));
    add_row(row_write(REG_REPLACE_HIGH, '1));
    add_row(row_write(REG_REPLACE_LEN, '1));
    add_row(row_text(ChA, 1'b0));
    add_row(row_text(ChQuote, 1'b0));
    add_row(row_text(ChA, 1'b0));
    // new length written while a byte is pending applies after the drain
    add_row(row_write(REG_SEARCH_LEN, '0));
    add_row(row_text(8'h63, 1'b1));
    add_row(row_text(ChA, 1'b0));
    add_row(row_text(ChQuote, 1'b1));
    add_row(row_write(REG_SEARCH_LEN, '1));
    add_row(row_pinned(ChA, 1'b1, {ChA, 1'b1, 1'b1, 1'b1}));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 63;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        pinned_q = {pinned_q, dir_tbl[i].pin};
        send_beat(dir_tbl[i].b, dir_tbl[i].last);
      end
    end
    setups += 4;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      settle();
      load_random_setup();
      goal = beats_in + PhaseItems;
      while (beats_in < goal) begin
        if ($urandom_range(3) == 0) begin
          settle();
          load_random_setup();
        end
        send_random_text();
      end
    end

    settle();
    if (text_out_q.size() != 0)
      report_mismatch("beats never seen", 32'(text_out_q.size()), 0);
    $display("Covered %0d input bytes in %0d texts, %0d output beats, %0d setups.",
             beats_in, texts_done, beats_out, setups);
    $display("Mismatches found: %0d", err_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
